FILE: design/sbfs_pkg.sv
// Shared types, codes and fixed-point constants of the stereo bass floor saturator.
package sbfs_pkg;

    localparam int FRAC            = 27;
    localparam int DW              = 40;
    localparam int MAW             = 36;
    localparam int MBW             = 30;
    localparam int QW              = 35;
    localparam int RATE_W          = 11;
    localparam int STAGE_COUNT_DEF = 5;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam logic signed [DW-1:0] ONE_Q         = 40'sd134217728;
    localparam logic signed [DW-1:0] THREE_ONE_Q   = 40'sd402653184;
    localparam logic signed [DW-1:0] S1_Q          = 40'sd210828714;
    localparam logic signed [DW-1:0] S3_Q          = 40'sd86699834;
    localparam logic signed [DW-1:0] S5_Q          = 40'sd10696163;
    localparam logic signed [DW-1:0] S7_Q          = 40'sd628374;
    localparam logic signed [DW-1:0] S9_Q          = 40'sd21534;
    localparam logic signed [DW-1:0] TWO_OVER_PI_Q = 40'sd85445659;
    localparam logic [29:0]          DIV3_K        = 30'd715827883;

    typedef enum logic [1:0] {
        REG_FLOOR,
        REG_DRIVE,
        REG_WET,
        REG_RATE
    } reg_idx_t;

    typedef enum logic [1:0] {
        SRC_LOW,
        SRC_AX,
        SRC_ARG
    } sin_src_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SET, OP_GAIN, OP_IIR, OP_CHIN, OP_OFF1, OP_OFF2,
        OP_COEF, OP_DIFF, OP_LMUL, OP_LADD, OP_ELEM, OP_SINP, OP_SINT2, OP_SINH,
        OP_SINF, OP_SUM, OP_GMUL, OP_CLIP, OP_A1, OP_A2, OP_A3, OP_A4,
        OP_BR, OP_XD, OP_XB, OP_WM, OP_DM, OP_MIX, OP_STORE, OP_OUT
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_SET, ST_GAIN, ST_DIVW, ST_IIR, ST_CHIN, ST_OFF1, ST_OFF2,
        ST_COEF, ST_DIFF, ST_LMUL, ST_LADD, ST_ELEM, ST_SINP, ST_SINT2, ST_SINH,
        ST_SINF, ST_SUM, ST_GMUL, ST_CLIP, ST_A1, ST_A2, ST_A3, ST_A4,
        ST_BR, ST_XD, ST_XB, ST_WM, ST_DM, ST_MIX, ST_STORE, ST_OUT
    } state_t;

    typedef struct packed {
        op_t        op;
        sin_src_t   src;
        logic [1:0] hk;
        logic       ch;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

    typedef struct packed {
        logic [15:0]       floor_amount;
        logic [15:0]       drive_amount;
        logic [15:0]       wet_mix;
        logic [RATE_W-1:0] rate_ratio;
    } cfg_t;

endpackage

FILE: design/stereo_bass_floor_saturator_core.sv
// Top level: register port, controller and datapath of the stereo bass floor saturator.
//
//   channel  direction  handshake          words
//   s_       in         s_valid/s_ready    s_left_in, s_right_in
//   m_       out        m_valid/m_ready    m_left_out, m_right_out
//   apb      in/out     psel/penable       floor, drive, wet, rate registers
//
// Each pair is paced by the single shared multiplier and the 35-step divider that sets
// the filter amount. s_ready is high only between pairs; a finished pair waits in the
// output register while the next pair is taken and computed. Reset clears the lowpass
// memories and the registers to their reset values; a stalled output holds the pair
// finished last.
module stereo_bass_floor_saturator_core #(
    parameter int STAGE_COUNT = sbfs_pkg::STAGE_COUNT_DEF,
    parameter int SAMPLE_BITS = sbfs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [SAMPLE_BITS-1:0] s_right_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import sbfs_pkg::*;

    localparam int STAGE_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

    logic [15:0]        floor_reg, drive_reg, wet_reg;
    logic [RATE_W-1:0]  rate_reg;
    cfg_t               cfg;
    cmd_t               cmd;
    stat_t              stat;
    logic [STAGE_W-1:0] stage;
    reg_idx_t           idx;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= 16'd0;
            drive_reg <= 16'd0;
            wet_reg   <= 16'hFFFF;
            rate_reg  <= RATE_W'(256);
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_FLOOR: floor_reg <= pwdata[15:0];
                REG_DRIVE: drive_reg <= pwdata[15:0];
                REG_WET:   wet_reg   <= pwdata[15:0];
                REG_RATE:  rate_reg  <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FLOOR: prdata = {16'd0, floor_reg};
            REG_DRIVE: prdata = {16'd0, drive_reg};
            REG_WET:   prdata = {16'd0, wet_reg};
            REG_RATE:  prdata = {{(32 - RATE_W){1'b0}}, rate_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg = '{floor_amount: floor_reg, drive_amount: drive_reg,
                   wet_mix: wet_reg, rate_ratio: rate_reg};

    sbfs_ctrl #(.STAGE_COUNT(STAGE_COUNT)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .stage   (stage)
    );

    sbfs_dp #(.STAGE_COUNT(STAGE_COUNT), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stage       (stage),
        .cfg         (cfg),
        .s_left_in   (s_left_in),
        .s_right_in  (s_right_in),
        .stat        (stat),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

endmodule

FILE: design/sbfs_div.sv
// Restoring divider, one quotient bit per cycle, for the filter amount.
module sbfs_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [sbfs_pkg::QW-1:0]     dividend,
    input  logic [sbfs_pkg::RATE_W-1:0] divisor,
    output logic [sbfs_pkg::QW-1:0]     quot,
    output logic                      busy
);
    import sbfs_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]     num_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] den_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic [RATE_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, num_reg[QW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= (divisor == '0) ? RATE_W'(1) : divisor;
        end else if (busy_reg) begin
            num_reg <= {num_reg[QW-2:0], ge};
            rem_reg <= ge ? RATE_W'(trial - {1'b0, den_reg}) : trial[RATE_W-1:0];
        end
    end

    assign quot = num_reg;
    assign busy = busy_reg;

endmodule

FILE: design/sbfs_dp.sv
// Datapath: shared rounding multiplier, work registers, lowpass memories and output words.
module sbfs_dp #(
    parameter  int STAGE_COUNT = sbfs_pkg::STAGE_COUNT_DEF,
    parameter  int SAMPLE_BITS = sbfs_pkg::SAMPLE_BITS_DEF,
    localparam int STAGE_W     = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sbfs_pkg::cmd_t                cmd,
    input  logic [STAGE_W-1:0]            stage,
    input  sbfs_pkg::cfg_t                cfg,
    input  logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [SAMPLE_BITS-1:0] s_right_in,
    output sbfs_pkg::stat_t               stat,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out
);
    import sbfs_pkg::*;

    localparam int SH = FRAC + 1 - SAMPLE_BITS;
    localparam logic signed [DW-1:0] SAT_HI = 40'sd2147483647;
    localparam logic signed [DW-1:0] SAT_LO = -40'sd2147483648;
    localparam logic signed [DW-1:0] OUT_HI = (DW'(1) <<< (SAMPLE_BITS - 1)) - DW'(1);
    localparam logic signed [DW-1:0] OUT_LO = -OUT_HI - DW'(1);

    function automatic logic signed [DW-1:0] mulq(input logic signed [MAW-1:0] a,
                                                  input logic signed [MBW-1:0] b);
        logic [MAW-1:0]     ma;
        logic [MBW-1:0]     mb;
        logic [MAW+MBW-1:0] pr;
        logic [DW-1:0]      m;
        ma = a[MAW-1] ? MAW'(-a) : MAW'(a);
        mb = b[MBW-1] ? MBW'(-b) : MBW'(b);
        pr = {{MBW{1'b0}}, ma} * {{MAW{1'b0}}, mb};
        pr = pr + ((MAW+MBW)'(1) << (FRAC - 1));
        m  = DW'(pr >> FRAC);
        return (a[MAW-1] ^ b[MBW-1]) ? -signed'(m) : signed'(m);
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [DW-1:0] v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic logic signed [DW-1:0] frac_q(input logic [15:0] v);
        return (v == 16'hFFFF) ? ONE_Q : signed'(DW'({v, 11'b0}));
    endfunction

    logic signed [SAMPLE_BITS-1:0] in_l_reg, in_r_reg;
    logic signed [SAMPLE_BITS-1:0] res_l_reg, res_r_reg;
    logic signed [SAMPLE_BITS-1:0] m_left_reg, m_right_reg;
    logic signed [DW-1:0] x_reg, dry_reg, t_reg, u_reg, low_reg, ax_reg, s1_reg, arg_reg;
    logic signed [DW-1:0] sx_reg, t2_reg, acc_reg, coef_reg, off_reg;
    logic signed [DW-1:0] setting_reg, gain_reg, iir_reg;
    logic [1:0]           quad_reg;
    logic signed [31:0]   lows_reg [2][STAGE_COUNT];

    logic signed [DW-1:0] f_q, d_q, wet_q, one_d, one_wet;
    logic signed [DW-1:0] lows_rd, mul_a, mul_b, mul_p, hc, sin_p, sin_t, xin, lnew;
    logic signed [DW-1:0] xc, out_r, out_s, sext, quot_q;
    logic [58:0]          div3_p;
    logic [QW-1:0]        quot;
    logic                 div_busy;
    logic signed [SAMPLE_BITS-1:0] sample;

    assign f_q     = frac_q(cfg.floor_amount);
    assign d_q     = frac_q(cfg.drive_amount);
    assign wet_q   = frac_q(cfg.wet_mix);
    assign one_d   = ONE_Q - d_q;
    assign one_wet = ONE_Q - wet_q;
    assign lows_rd = DW'(lows_reg[cmd.ch][stage]);
    assign sample  = cmd.ch ? in_r_reg : in_l_reg;
    assign sext    = DW'(sample);
    assign lnew    = sat32(lows_rd + t_reg);
    assign div3_p  = 59'(t_reg[28:0]) * 59'(DIV3_K);
    assign quot_q  = signed'(DW'(quot));

    generate
        if (SH >= 0) begin : g_in_exact
            assign xin = sext <<< SH;
        end else begin : g_in_round
            logic signed [DW-1:0] mag, m;
            assign mag = (sext < 0) ? -sext : sext;
            assign m   = (mag + (DW'(1) <<< (-SH - 1))) >>> (-SH);
            assign xin = (sext < 0) ? -m : m;
        end
        if (SH > 0) begin : g_out_round
            logic signed [DW-1:0] mag, m;
            assign mag   = (x_reg < 0) ? -x_reg : x_reg;
            assign m     = (mag + (DW'(1) <<< (SH - 1))) >>> SH;
            assign out_r = (x_reg < 0) ? -m : m;
        end else begin : g_out_exact
            assign out_r = x_reg <<< (-SH);
        end
    endgenerate

    assign out_s = (out_r > OUT_HI) ? OUT_HI : ((out_r < OUT_LO) ? OUT_LO : out_r);
    assign xc    = (x_reg > ONE_Q) ? ONE_Q : ((x_reg < -ONE_Q) ? -ONE_Q : x_reg);

    always_comb begin
        case (cmd.src)
            SRC_LOW: sin_p = low_reg;
            SRC_AX:  sin_p = ax_reg;
            SRC_ARG: sin_p = arg_reg;
            default: sin_p = low_reg;
        endcase
        sin_t = signed'(DW'(sin_p[26:0]));
        if (sin_p[27]) begin
            sin_t = ONE_Q - sin_t;
        end
    end

    always_comb begin
        case (cmd.hk)
            2'd0:    hc = -S7_Q;
            2'd1:    hc = S5_Q;
            2'd2:    hc = -S3_Q;
            default: hc = S1_Q;
        endcase
    end

    always_comb begin
        case (cmd.op)
            OP_SET:   begin mul_a = f_q;     mul_b = f_q;           end
            OP_COEF:  begin mul_a = off_reg; mul_b = iir_reg;       end
            OP_LMUL:  begin mul_a = t_reg;   mul_b = coef_reg;      end
            OP_GMUL:  begin mul_a = u_reg;   mul_b = gain_reg;      end
            OP_SINT2: begin mul_a = sx_reg;  mul_b = sx_reg;        end
            OP_SINH:  begin mul_a = acc_reg; mul_b = t2_reg;        end
            OP_SINF:  begin mul_a = acc_reg; mul_b = sx_reg;        end
            OP_A1:    begin mul_a = ax_reg;  mul_b = one_d;         end
            OP_A2:    begin mul_a = t_reg;   mul_b = TWO_OVER_PI_Q; end
            OP_A3:    begin mul_a = s1_reg;  mul_b = d_q;           end
            OP_BR:    begin mul_a = acc_reg; mul_b = d_q;           end
            OP_XD:    begin mul_a = x_reg;   mul_b = one_d;         end
            OP_WM:    begin mul_a = x_reg;   mul_b = wet_q;         end
            OP_DM:    begin mul_a = dry_reg; mul_b = one_wet;       end
            default:  begin mul_a = '0;      mul_b = '0;            end
        endcase
        mul_p = mulq(signed'(mul_a[MAW-1:0]), signed'(mul_b[MBW-1:0]));
    end

    sbfs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == OP_GAIN),
        .dividend ({setting_reg[27:0], 7'b0}),
        .divisor  (cfg.rate_ratio),
        .quot     (quot),
        .busy     (div_busy)
    );

    assign stat.div_done = !div_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 2; c++) begin
                for (int s = 0; s < STAGE_COUNT; s++) begin
                    lows_reg[c][s] <= '0;
                end
            end
        end else if (cmd.op == OP_LADD) begin
            lows_reg[cmd.ch][stage] <= lnew[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                in_l_reg <= s_left_in;
                in_r_reg <= s_right_in;
            end
            OP_SET:  setting_reg <= mul_p;
            OP_GAIN: gain_reg <= ONE_Q + (setting_reg >>> 2);
            OP_IIR:  iir_reg <= (quot_q > ONE_Q) ? ONE_Q : quot_q;
            OP_CHIN: begin
                x_reg   <= xin;
                dry_reg <= xin;
            end
            OP_OFF1: t_reg <= ((x_reg < 0) ? -x_reg : x_reg) + ONE_Q;
            OP_OFF2: off_reg <= (t_reg >= THREE_ONE_Q) ? ONE_Q
                                                       : signed'(DW'(div3_p[58:31]));
            OP_COEF: coef_reg <= mul_p;
            OP_DIFF: t_reg <= x_reg - lows_rd;
            OP_LMUL: t_reg <= mul_p;
            OP_LADD: low_reg <= lnew;
            OP_ELEM: u_reg <= x_reg - (low_reg <<< 1);
            OP_SINP: begin
                sx_reg   <= sin_t;
                quad_reg <= sin_p[28:27];
            end
            OP_SINT2: begin
                t2_reg  <= mul_p;
                acc_reg <= S9_Q;
            end
            OP_SINH: acc_reg <= mul_p + hc;
            OP_SINF: acc_reg <= quad_reg[1] ? -mul_p : mul_p;
            OP_SUM:  u_reg <= u_reg + acc_reg;
            OP_GMUL: x_reg <= sat32(mul_p);
            OP_CLIP: begin
                x_reg  <= xc;
                ax_reg <= (xc < 0) ? -xc : xc;
            end
            OP_A1: begin
                s1_reg <= acc_reg;
                t_reg  <= mul_p;
            end
            OP_A2:  t_reg <= mul_p;
            OP_A3:  u_reg <= mul_p;
            OP_A4:  arg_reg <= t_reg + u_reg;
            OP_BR:  u_reg <= mul_p;
            OP_XD:  t_reg <= mul_p;
            OP_XB:  x_reg <= (x_reg > 0) ? (t_reg + u_reg) : (t_reg - u_reg);
            OP_WM:  t_reg <= mul_p;
            OP_DM:  u_reg <= mul_p;
            OP_MIX: begin
                if (wet_q != ONE_Q) begin
                    x_reg <= t_reg + u_reg;
                end
            end
            OP_STORE: begin
                if (cmd.ch) begin
                    res_r_reg <= out_s[SAMPLE_BITS-1:0];
                end else begin
                    res_l_reg <= out_s[SAMPLE_BITS-1:0];
                end
            end
            OP_OUT: begin
                m_left_reg  <= res_l_reg;
                m_right_reg <= res_r_reg;
            end
            default: ;
        endcase
    end

    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;

endmodule

FILE: design/sbfs_ctrl.sv
// Controller: sequences the datapath through setup, the stage loop, drive and mix.
module sbfs_ctrl #(
    parameter  int STAGE_COUNT = sbfs_pkg::STAGE_COUNT_DEF,
    localparam int STAGE_W     = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  sbfs_pkg::stat_t    stat,
    output sbfs_pkg::cmd_t     cmd,
    output logic [STAGE_W-1:0] stage
);
    import sbfs_pkg::*;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    sin_src_t           src_reg, src_next;
    logic [1:0]         hk_reg, hk_next;
    logic               ch_reg, ch_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            src_reg     <= SRC_LOW;
            hk_reg      <= '0;
            ch_reg      <= 1'b0;
            stage_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            src_reg     <= src_next;
            hk_reg      <= hk_next;
            ch_reg      <= ch_next;
            stage_reg   <= stage_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        src_next     = src_reg;
        hk_next      = hk_reg;
        ch_next      = ch_reg;
        stage_next   = stage_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SET;
                    ch_next    = 1'b0;
                    stage_next = '0;
                end
            end
            ST_SET:  state_next = ST_GAIN;
            ST_GAIN: state_next = ST_DIVW;
            ST_DIVW: begin
                if (stat.div_done) begin
                    state_next = ST_IIR;
                end
            end
            ST_IIR:  state_next = ST_CHIN;
            ST_CHIN: state_next = ST_OFF1;
            ST_OFF1: state_next = ST_OFF2;
            ST_OFF2: state_next = ST_COEF;
            ST_COEF: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_LMUL;
            ST_LMUL: state_next = ST_LADD;
            ST_LADD: state_next = ST_ELEM;
            ST_ELEM: begin
                state_next = ST_SINP;
                src_next   = SRC_LOW;
                ret_next   = ST_SUM;
            end
            ST_SINP: begin
                state_next = ST_SINT2;
                hk_next    = '0;
            end
            ST_SINT2: state_next = ST_SINH;
            ST_SINH: begin
                if (hk_reg == 2'd3) begin
                    state_next = ST_SINF;
                end
                hk_next = hk_reg + 2'd1;
            end
            ST_SINF: state_next = ret_reg;
            ST_SUM:  state_next = ST_GMUL;
            ST_GMUL: begin
                if (stage_reg == STAGE_W'(STAGE_COUNT - 1)) begin
                    state_next = ST_CLIP;
                end else begin
                    state_next = ST_OFF1;
                    stage_next = stage_reg + 1'b1;
                end
            end
            ST_CLIP: begin
                state_next = ST_SINP;
                src_next   = SRC_AX;
                ret_next   = ST_A1;
            end
            ST_A1: state_next = ST_A2;
            ST_A2: state_next = ST_A3;
            ST_A3: state_next = ST_A4;
            ST_A4: begin
                state_next = ST_SINP;
                src_next   = SRC_ARG;
                ret_next   = ST_BR;
            end
            ST_BR:  state_next = ST_XD;
            ST_XD:  state_next = ST_XB;
            ST_XB:  state_next = ST_WM;
            ST_WM:  state_next = ST_DM;
            ST_DM:  state_next = ST_MIX;
            ST_MIX: state_next = ST_STORE;
            ST_STORE: begin
                if (!ch_reg) begin
                    state_next = ST_CHIN;
                    ch_next    = 1'b1;
                    stage_next = '0;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.src = src_reg;
        cmd.hk  = hk_reg;
        cmd.ch  = ch_reg;
        case (state_reg)
            ST_IDLE:  cmd.op = s_valid ? OP_LOAD : OP_NONE;
            ST_SET:   cmd.op = OP_SET;
            ST_GAIN:  cmd.op = OP_GAIN;
            ST_DIVW:  cmd.op = OP_NONE;
            ST_IIR:   cmd.op = OP_IIR;
            ST_CHIN:  cmd.op = OP_CHIN;
            ST_OFF1:  cmd.op = OP_OFF1;
            ST_OFF2:  cmd.op = OP_OFF2;
            ST_COEF:  cmd.op = OP_COEF;
            ST_DIFF:  cmd.op = OP_DIFF;
            ST_LMUL:  cmd.op = OP_LMUL;
            ST_LADD:  cmd.op = OP_LADD;
            ST_ELEM:  cmd.op = OP_ELEM;
            ST_SINP:  cmd.op = OP_SINP;
            ST_SINT2: cmd.op = OP_SINT2;
            ST_SINH:  cmd.op = OP_SINH;
            ST_SINF:  cmd.op = OP_SINF;
            ST_SUM:   cmd.op = OP_SUM;
            ST_GMUL:  cmd.op = OP_GMUL;
            ST_CLIP:  cmd.op = OP_CLIP;
            ST_A1:    cmd.op = OP_A1;
            ST_A2:    cmd.op = OP_A2;
            ST_A3:    cmd.op = OP_A3;
            ST_A4:    cmd.op = OP_A4;
            ST_BR:    cmd.op = OP_BR;
            ST_XD:    cmd.op = OP_XD;
            ST_XB:    cmd.op = OP_XB;
            ST_WM:    cmd.op = OP_WM;
            ST_DM:    cmd.op = OP_DM;
            ST_MIX:   cmd.op = OP_MIX;
            ST_STORE: cmd.op = OP_STORE;
            ST_OUT:   cmd.op = out_free ? OP_OUT : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign stage   = stage_reg;

endmodule

FILE: design/sbfs_checker.sv
// Port-level checks of the stereo bass floor saturator, bound to the top level.
module sbfs_checker #(
    parameter int SAMPLE_BITS = sbfs_pkg::SAMPLE_BITS_DEF
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [SAMPLE_BITS-1:0] m_left_out,
    input logic [SAMPLE_BITS-1:0] m_right_out
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_out) && $stable(m_right_out))
        else $error("stalled output word changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a pair is in work");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared right after accept");

endmodule

bind stereo_bass_floor_saturator_core sbfs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_left_out  (m_left_out),
    .m_right_out (m_right_out)
);
